// ===== rtl/stcd_pkg.sv =====
// Shared constants and the month-start table for the seconds-to-civil-date pipeline.
// No dependencies; used by seconds_to_civil_datetime.sv.
`default_nettype none

package stcd_pkg;

  // Seconds in one day and days in one 400-year era
  localparam longint SEC_PER_DAY  = 64'sd86400;
  localparam longint DAYS_PER_ERA = 64'sd146097;
  // Days from 0000-03-01 to 1970-01-01
  localparam longint DAYS_FROM_MAR0 = 64'sd719468;

  // Bias that lifts every 41-bit input to a non-negative second count,
  // a whole number of days so the day split stays exact
  localparam longint DAY_BIAS = ((64'sd1 <<< 40) + SEC_PER_DAY - 64'sd1) / SEC_PER_DAY;
  localparam logic [41:0] SEC_BIAS = 42'(DAY_BIAS * SEC_PER_DAY);

  // Whole eras added so the shifted day number is never negative
  localparam longint ERA_BIAS_L =
    (DAY_BIAS - DAYS_FROM_MAR0 + DAYS_PER_ERA - 64'sd1) / DAYS_PER_ERA;
  localparam logic [16:0] ERA_BIAS = 17'(ERA_BIAS_L);
  localparam logic [24:0] DN_OFS =
    25'(DAYS_FROM_MAR0 - DAY_BIAS + DAYS_PER_ERA * ERA_BIAS_L);

  // Last day of an era (the extra leap day of the 400th year)
  localparam logic [17:0] ERA_LAST_DAY = 18'd146096;

  // March-based month index at which January starts
  localparam logic [3:0] MP_JAN = 4'd10;

  // Pipeline depth from the start beat to the result strobe
  localparam int LAT = 27;

  // First day of year of a March-based month
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] d;
    case (mp)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd61;
      4'd3:    d = 9'd92;
      4'd4:    d = 9'd122;
      4'd5:    d = 9'd153;
      4'd6:    d = 9'd184;
      4'd7:    d = 9'd214;
      4'd8:    d = 9'd245;
      4'd9:    d = 9'd275;
      4'd10:   d = 9'd306;
      4'd11:   d = 9'd337;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/stcd_divc.sv =====
// Pipelined unsigned divider by a constant: reciprocal multiply, then one correction.
// Standalone; instantiated several times by seconds_to_civil_datetime.sv.
`default_nettype none

module stcd_divc #(
  parameter int W = 8,
  parameter int D = 3,
  localparam int M  = (2 ** W) / D,
  localparam int QW = $clog2(M + 1),
  localparam int RW = $clog2(D)
) (
  input  logic          clk,
  input  logic [W-1:0]  n,
  output logic [QW-1:0] q,
  output logic [RW-1:0] r
);

  localparam logic [W-1:0] DW = W'(D);
  localparam logic [RW:0]  DR = (RW + 1)'(D);

  logic [W+QW-1:0] prod;
  logic [W+QW-1:0] prod_r;
  logic [W-1:0]    n1_r;
  logic [QW-1:0]   qe;
  logic [QW-1:0]   qe_r;
  logic [W-1:0]    qd;
  logic [W-1:0]    r0;
  logic [RW:0]     r0_r;
  logic [QW-1:0]   q_r;
  logic [RW-1:0]   r_r;

  // Estimate quotient: never high, at most one low
  assign prod = (W + QW)'(n) * (W + QW)'(M);
  assign qe   = prod_r[W+QW-1:W];
  assign qd   = W'(qe) * DW;
  assign r0   = n1_r - qd;

  // Stage 1: multiply; stage 2: partial remainder; stage 3: correct
  always_ff @(posedge clk) begin
    prod_r <= prod;
    n1_r   <= n;
    qe_r   <= qe;
    r0_r   <= r0[RW:0];
    if (r0_r >= DR) begin
      q_r <= qe_r + QW'(1);
      r_r <= RW'(r0_r - DR);
    end else begin
      q_r <= qe_r;
      r_r <= r0_r[RW-1:0];
    end
  end

  assign q = q_r;
  assign r = r_r;

endmodule

`default_nettype wire

// ===== rtl/seconds_to_civil_datetime.sv =====
// Timing: the result strobe out_valid follows the start beat down the valid pipeline.
// Throughput: one beat per cycle; busy stays low, results leave in accept order.
// Depth is set by the chain of constant dividers (three stages each) on the date path.
// Reset (synchronous, rst_n low) clears the valid pipeline; data registers are not reset.
// Top level: converts signed epoch seconds to proleptic Gregorian date and UTC time.
// Depends on stcd_pkg and stcd_divc.
`default_nettype none

module seconds_to_civil_datetime (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [40:0] in_epoch_seconds,
  output logic               out_valid,
  output logic signed [16:0] out_year,
  output logic [3:0]         out_month,
  output logic [4:0]         out_day_of_month,
  output logic [4:0]         out_hour,
  output logic [5:0]         out_minute,
  output logic [5:0]         out_second
);

  localparam int LAT = stcd_pkg::LAT;

  logic [LAT-1:0] vld_r;

  logic [41:0] u_r;
  logic [9:0]  qh_s4;
  logic [9:0]  rh_s4;
  logic [22:0] lo_d_r [3];
  logic [16:0] hl_d_r [3];
  logic [16:0] ql_s7;
  logic [9:0]  remb_s7;
  logic [24:0] dn_r;
  logic [16:0] sod_r;
  logic [7:0]  era_s11;
  logic [17:0] doe_s11;
  logic [11:0] mt_s11;
  logic [5:0]  sec_s11;
  logic [5:0]  hr_s14;
  logic [5:0]  min_s14;
  logic [5:0]  sec_d_r [3];
  logic [16:0] tim_d_r [12];
  logic [7:0]  q1460_s14;
  logic [2:0]  q36524_s14;
  logic [17:0] doe_d_r [10];
  logic [7:0]  era_d_r [10];
  logic [17:0] tmp_r;
  logic [9:0]  yoe_s18;
  logic [8:0]  yoe_d_r [3];
  logic [2:0]  c100_s21;
  logic [17:0] doe_s21;
  logic [8:0]  yoe_s21;
  logic [17:0] doy_full;
  logic signed [16:0] era_sx;
  logic signed [16:0] base;
  logic [8:0]  doy_r;
  logic signed [16:0] base_r;
  logic [10:0] n_r;
  logic [8:0]  doy_d_r [4];
  logic signed [16:0] base_d_r [4];
  logic [3:0]  mp_s26;
  logic [8:0]  day_full;

  // Accept a beat every cycle
  assign busy = 1'b0;

  // Advance the valid bits alongside the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], start & ~busy};
    end
  end
  assign out_valid = vld_r[LAT-1];

  // Stage 1: bias the input to a non-negative whole-day offset
  always_ff @(posedge clk) begin
    u_r <= {in_epoch_seconds[40], in_epoch_seconds} + stcd_pkg::SEC_BIAS;
  end

  // Days = (u >> 7) / 675, split into a high and a low half of the dividend
  stcd_divc #(.W(19), .D(675)) u_div_hi (
    .clk (clk), .n (u_r[41:23]), .q (qh_s4), .r (rh_s4)
  );

  // Hold the low dividend bits and the high quotient across the dividers
  always_ff @(posedge clk) begin
    lo_d_r[0] <= u_r[22:0];
    lo_d_r[1] <= lo_d_r[0];
    lo_d_r[2] <= lo_d_r[1];
    hl_d_r[0] <= {qh_s4, lo_d_r[2][6:0]};
    hl_d_r[1] <= hl_d_r[0];
    hl_d_r[2] <= hl_d_r[1];
  end

  stcd_divc #(.W(26), .D(675)) u_div_lo (
    .clk (clk), .n ({rh_s4, lo_d_r[2][22:7]}), .q (ql_s7), .r (remb_s7)
  );

  // Stage 8: day number from 0000-03-01 (era-biased) and second of day
  always_ff @(posedge clk) begin
    dn_r  <= 25'({hl_d_r[2][16:7], ql_s7[15:0]}) + stcd_pkg::DN_OFS;
    sod_r <= {remb_s7, hl_d_r[2][6:0]};
  end

  // Era and day of era
  stcd_divc #(.W(25), .D(146097)) u_div_era (
    .clk (clk), .n (dn_r), .q (era_s11), .r (doe_s11)
  );

  // Time of day: seconds, then minutes and hours
  stcd_divc #(.W(17), .D(60)) u_div_sec (
    .clk (clk), .n (sod_r), .q (mt_s11), .r (sec_s11)
  );

  stcd_divc #(.W(11), .D(60)) u_div_min (
    .clk (clk), .n (mt_s11[10:0]), .q (hr_s14), .r (min_s14)
  );

  // Delay the time fields to line up with the date
  always_ff @(posedge clk) begin
    sec_d_r[0] <= sec_s11;
    sec_d_r[1] <= sec_d_r[0];
    sec_d_r[2] <= sec_d_r[1];
    tim_d_r[0] <= {hr_s14[4:0], min_s14, sec_d_r[2]};
    for (int i = 1; i < 12; i++) begin
      tim_d_r[i] <= tim_d_r[i-1];
    end
  end

  // Leap corrections for the year of era
  stcd_divc #(.W(18), .D(1460)) u_div_1460 (
    .clk (clk), .n (doe_s11), .q (q1460_s14), .r ()
  );

  stcd_divc #(.W(18), .D(36524)) u_div_36524 (
    .clk (clk), .n (doe_s11), .q (q36524_s14), .r ()
  );

  // Carry day of era and era down the date path
  always_ff @(posedge clk) begin
    doe_d_r[0] <= doe_s11;
    era_d_r[0] <= era_s11;
    for (int i = 1; i < 10; i++) begin
      doe_d_r[i] <= doe_d_r[i-1];
      era_d_r[i] <= era_d_r[i-1];
    end
  end

  // Stage 15: day of era with leap days removed
  always_ff @(posedge clk) begin
    tmp_r <= doe_d_r[2] - 18'(q1460_s14) + 18'(q36524_s14)
             - 18'(doe_d_r[2] == stcd_pkg::ERA_LAST_DAY);
  end

  stcd_divc #(.W(18), .D(365)) u_div_yoe (
    .clk (clk), .n (tmp_r), .q (yoe_s18), .r ()
  );

  stcd_divc #(.W(9), .D(100)) u_div_cent (
    .clk (clk), .n (yoe_s18[8:0]), .q (c100_s21), .r ()
  );

  always_ff @(posedge clk) begin
    yoe_d_r[0] <= yoe_s18[8:0];
    yoe_d_r[1] <= yoe_d_r[0];
    yoe_d_r[2] <= yoe_d_r[1];
  end

  assign doe_s21 = doe_d_r[9];
  assign yoe_s21 = yoe_d_r[2];

  // Day of year and the year before the January/February adjustment
  assign doy_full = doe_s21 - 18'(yoe_s21) * 18'd365 - 18'(yoe_s21[8:2]) + 18'(c100_s21);
  assign era_sx   = $signed(17'(era_d_r[9])) - $signed(stcd_pkg::ERA_BIAS);
  assign base     = era_sx * 17'sd400 + $signed({8'b0, yoe_s21});

  // Stage 22 and 23: register day of year, then form the month dividend
  always_ff @(posedge clk) begin
    doy_r       <= doy_full[8:0];
    base_r      <= base;
    n_r         <= 11'({2'b0, doy_r} * 11'd5 + 11'd2);
    doy_d_r[0]  <= doy_r;
    base_d_r[0] <= base_r;
    for (int i = 1; i < 4; i++) begin
      doy_d_r[i]  <= doy_d_r[i-1];
      base_d_r[i] <= base_d_r[i-1];
    end
  end

  stcd_divc #(.W(11), .D(153)) u_div_mon (
    .clk (clk), .n (n_r), .q (mp_s26), .r ()
  );

  assign day_full = doy_d_r[3] - stcd_pkg::month_start(mp_s26) + 9'd1;

  // Stage 27: map to January-based month and drive the result beat
  always_ff @(posedge clk) begin
    out_day_of_month <= day_full[4:0];
    if (mp_s26 >= stcd_pkg::MP_JAN) begin
      out_month <= mp_s26 - 4'd9;
      out_year  <= base_d_r[3] + 17'sd1;
    end else begin
      out_month <= mp_s26 + 4'd3;
      out_year  <= base_d_r[3];
    end
    out_hour   <= tim_d_r[11][16:12];
    out_minute <= tim_d_r[11][11:6];
    out_second <= tim_d_r[11][5:0];
  end

  // Result beats carry a calendar-consistent month and day
  a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_month >= 4'd1 && out_month <= 4'd12 && out_day_of_month >= 5'd1))
    else $error("month or day out of range");

  a_feb_days: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_month == 4'd2) |-> (out_day_of_month <= 5'd29))
    else $error("February day beyond 29");

  a_short_months: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_month == 4'd4 || out_month == 4'd6 ||
                   out_month == 4'd9 || out_month == 4'd11))
    |-> (out_day_of_month <= 5'd30))
    else $error("30-day month beyond day 30");

  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hour <= 5'd23 && out_minute <= 6'd59 && out_second <= 6'd59))
    else $error("time of day out of range");

endmodule

`default_nettype wire
